// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands used by the port-level checker module
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// a word offered on a valid/ready channel stays put until it is taken
`define ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, data, msg) \
  `ASSERT_CLK(lbl, clk, rst_n, (vld && !rdy) |=> (vld && $stable(data)), msg)

`endif

// ===== rtl/core/isr64_pkg.sv =====
// ---------------------------------------------------------------------------
// isr64_pkg
// widths, stage record and the one-bit root step of the square root pipe
// ---------------------------------------------------------------------------
package isr64_pkg;

  localparam int RAD_W      = 64;
  localparam int ROOT_W     = RAD_W / 2;
  // remainder never exceeds twice the partial root
  localparam int REM_W      = ROOT_W + 1;
  localparam int NUM_STAGES = ROOT_W;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] q;
    logic [RAD_W-1:0]  rad;  // radicand bits not yet consumed, left aligned
  } step_t;

  // bring down the next two radicand bits and decide one root bit
  function automatic step_t sqrt_step(step_t cur);
    logic [REM_W+1:0] cat;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    step_t            nxt;
    cat   = {cur.rem, cur.rad[RAD_W-1 -: 2]};
    trial = {1'b0, cur.q, 2'b01};
    diff  = cat - trial;
    nxt.rad = {cur.rad[RAD_W-3:0], 2'b00};
    if (cat >= trial) begin
      nxt.rem = diff[REM_W-1:0];
      nxt.q   = {cur.q[ROOT_W-2:0], 1'b1};
    end else begin
      nxt.rem = cat[REM_W-1:0];
      nxt.q   = {cur.q[ROOT_W-2:0], 1'b0};
    end
    return nxt;
  endfunction

endpackage

// ===== rtl/core/integer_square_root_64_top.sv =====
// ---------------------------------------------------------------------------
// integer_square_root_64_top
// pipelined floor square root of an unsigned 64-bit word
// ---------------------------------------------------------------------------
// usage
//   input channel : in_valid / in_ready / in_radicand (64-bit unsigned word)
//   result channel: out_valid / out_ready / out_root (32-bit floor root)
//   a word moves on a channel at a rising edge with valid and ready high
// timing
//   one root bit is decided per stage, 32 stages, then an output register:
//   a word accepted on the input passes through every stage and the
//   output register to out_root; while the pipe does not stall,
//   throughput is one word per cycle, set by the one-bit-per-stage pipe
// reset
//   rst_n is synchronous, active low; it drops all words in flight and
//   in_ready is high from the first reset edge on
// stall
//   a word held on the output lets one more finished word land in a skid
//   register; while that register is full in_ready is low and every stage
//   holds, so nothing is lost or repeated
// ---------------------------------------------------------------------------
module integer_square_root_64_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [isr64_pkg::RAD_W-1:0]  in_radicand,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [isr64_pkg::ROOT_W-1:0] out_root
);
  import isr64_pkg::*;

  // stage registers, one root bit each
  logic  vld_r [NUM_STAGES];
  step_t stg_r [NUM_STAGES];
  step_t stg_nxt [NUM_STAGES];

  // output register and skid register
  logic              out_vld_r, out_vld_nxt;
  logic [ROOT_W-1:0] out_root_r, out_root_nxt;
  logic              skid_vld_r, skid_vld_nxt;
  logic [ROOT_W-1:0] skid_root_r, skid_root_nxt;

  logic  adv;       // whole pipe moves one stage
  step_t stg_in;    // record entering stage zero

  assign adv      = !skid_vld_r;
  assign in_ready = adv;

  assign stg_in.rem = '0;
  assign stg_in.q   = '0;
  assign stg_in.rad = in_radicand;

  // the same step in every stage, stage zero on the input record, each other on its predecessor
  always_comb begin
    stg_nxt[0] = sqrt_step(stg_in);
    for (int s = 1; s < NUM_STAGES; s++) begin
      stg_nxt[s] = sqrt_step(stg_r[s-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_STAGES; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int s = 1; s < NUM_STAGES; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  // payload carries no reset
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < NUM_STAGES; s++) begin
        stg_r[s] <= stg_nxt[s];
      end
    end
  end

  // output side: the skid register fills only while the output word waits
  always_comb begin
    out_vld_nxt   = out_vld_r;
    out_root_nxt  = out_root_r;
    skid_vld_nxt  = skid_vld_r;
    skid_root_nxt = skid_root_r;
    if (skid_vld_r) begin
      // pipe is frozen; drain skid into the output once taken
      if (out_ready) begin
        out_root_nxt = skid_root_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (out_vld_r && !out_ready) begin
      if (vld_r[NUM_STAGES-1]) begin
        skid_vld_nxt  = 1'b1;
        skid_root_nxt = stg_r[NUM_STAGES-1].q;
      end
    end else begin
      out_vld_nxt  = vld_r[NUM_STAGES-1];
      out_root_nxt = stg_r[NUM_STAGES-1].q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_root_r  <= out_root_nxt;
    skid_root_r <= skid_root_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_root  = out_root_r;

endmodule

// ===== rtl/core/isr64_checker.sv =====
// ---------------------------------------------------------------------------
// isr64_checker
// port-level checks of the square root pipe, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module isr64_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [isr64_pkg::ROOT_W-1:0] out_root
);
  import isr64_pkg::*;

  logic in_seen;
  assign in_seen = in_valid;

  // result word held while stalled
  `ASSERT_HOLD(a_out_hold, clk, rst_n, out_valid, out_ready, out_root, "out word changed under stall")

  // back pressure only while a result word is waiting
  `ASSERT_CLK(a_ready_low_has_out, clk, rst_n, !in_ready |-> out_valid, "in_ready low with no out word")

  // back pressure is released the cycle after a waiting word is taken
  `ASSERT_CLK(a_ready_recovers, clk, rst_n, (!in_ready && out_ready) |=> in_ready, "in_ready stuck low")

  // input side cannot stall while the output drains freely
  `ASSERT_CLK(a_no_stall_free, clk, rst_n, (in_seen && out_ready && in_ready) |=> in_ready, "stall with free output")

endmodule

bind integer_square_root_64_top isr64_checker u_isr64_checker (.*);

// ===== dv/isr64_root_checker.sv =====
// ---------------------------------------------------------------------------
// isr64_root_checker
// watches both channels, predicts the floor root of every accepted radicand
// and compares it with the words that leave the block, in order
// ---------------------------------------------------------------------------
module isr64_root_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [isr64_pkg::RAD_W-1:0]  in_radicand,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [isr64_pkg::ROOT_W-1:0] out_root,
  output int                           mismatch_cnt,
  output int                           roots_in_flight,
  output int                           roots_checked,
  output int                           input_stall_cycles
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 20;

  logic [isr64_pkg::ROOT_W-1:0] expected_roots[$];

  // build the root one bit at a time, keeping a bit while its square still fits
  function automatic logic [isr64_pkg::ROOT_W-1:0] floor_sqrt64(
    input logic [isr64_pkg::RAD_W-1:0] v
  );
    logic [isr64_pkg::ROOT_W-1:0] r;
    logic [isr64_pkg::ROOT_W-1:0] trial;
    logic [isr64_pkg::RAD_W-1:0]  sq;
    r = '0;
    for (int b = isr64_pkg::ROOT_W - 1; b >= 0; b--) begin
      trial = r | (32'd1 << b);
      sq    = 64'(trial) * 64'(trial);
      if (sq <= v) r = trial;
    end
    return r;
  endfunction

  initial begin
    mismatch_cnt       = 0;
    roots_checked      = 0;
    input_stall_cycles = 0;
  end

  assign roots_in_flight = expected_roots.size();

  always @(posedge clk) begin
    logic [isr64_pkg::ROOT_W-1:0] want;
    if (rst_n) begin
      if (in_valid && in_ready) expected_roots.push_back(floor_sqrt64(in_radicand));
      if (in_valid && !in_ready) input_stall_cycles++;
      if (out_valid && out_ready) begin
        if (expected_roots.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("%0t: unexpected root word, expected none, actual %0d",
                     $time, out_root);
        end else begin
          want = expected_roots.pop_front();
          roots_checked++;
          if (out_root !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
              $display("%0t: root mismatch, expected %0d, actual %0d",
                       $time, want, out_root);
          end
        end
      end
    end
  end

endmodule

// ===== dv/tb_integer_square_root_64_top.sv =====
// ---------------------------------------------------------------------------
// tb_integer_square_root_64_top
// floor square root pipe driven with edge radicands, perfect squares and
// their neighbors, and random words, under bursty input and stalled output
// ---------------------------------------------------------------------------
module tb_integer_square_root_64_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 1880;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 200;   // long output hold-off, fills the pipe
  localparam int HOLD_AT_WORD = 300;   // start it once this many words went in
  localparam int DRAIN_CYCLES = 40;    // pipe depth plus margin

  logic                         clk         = 1'b0;
  logic                         rst_n       = 1'b0;
  logic                         in_valid    = 1'b0;
  logic                         in_ready;
  logic [isr64_pkg::RAD_W-1:0]  in_radicand = '0;
  logic                         out_valid;
  logic                         out_ready   = 1'b0;
  logic [isr64_pkg::ROOT_W-1:0] out_root;

  int mismatch_cnt;
  int roots_in_flight;
  int roots_checked;
  int input_stall_cycles;

  int words_sent   = 0;
  int burst_left   = 0;
  int cycle_cnt    = 0;
  bit hold_done    = 1'b0;

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  integer_square_root_64_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_radicand (in_radicand),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_root    (out_root)
  );

  isr64_root_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_radicand        (in_radicand),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_root           (out_root),
    .mismatch_cnt       (mismatch_cnt),
    .roots_in_flight    (roots_in_flight),
    .roots_checked      (roots_checked),
    .input_stall_cycles (input_stall_cycles)
  );

  // offer one word and hold it until taken; between bursts drop valid for a
  // random gap, and now and then run back to back with no gap at all
  task automatic send_word(input logic [isr64_pkg::RAD_W-1:0] v);
    int gap;
    in_valid    <= 1'b1;
    in_radicand <= v;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // random radicand, weighted toward perfect squares and their neighbors
  // since those sit right on a root step
  function automatic logic [isr64_pkg::RAD_W-1:0] pick_radicand();
    logic [isr64_pkg::RAD_W-1:0]  v;
    logic [isr64_pkg::ROOT_W-1:0] k;
    k = $urandom;
    case ($urandom_range(0, 6))
      0, 1:    v = {$urandom, $urandom};
      2:       v = 64'(k) * 64'(k);
      // one below the next square, still rounds down to k
      3:       v = 64'(k) * 64'(k) + {31'd0, k, 1'b0};
      // one below this square, rounds down to k-1
      4:       v = 64'(k) * 64'(k) - 64'd1;
      // short words, small roots
      5:       v = {$urandom, $urandom} >> $urandom_range(32, 63);
      default: v = {$urandom, $urandom} >> $urandom_range(1, 31);
    endcase
    return v;
  endfunction

  // output side: segments of always-ready, coin-flip and mostly-stalled,
  // plus one long hold-off while the input keeps pushing
  initial begin
    int mode;
    int seg_len;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && words_sent >= HOLD_AT_WORD) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      mode    = $urandom_range(0, 2);
      seg_len = $urandom_range(10, 80);
      repeat (seg_len) begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= $urandom_range(0, 1);
          default: out_ready <= ($urandom_range(0, 5) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // run limit
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb_integer_square_root_64_top: FAIL");
    $finish;
  end

  // reset, then stimulus, drain and verdict
  initial begin
    logic [isr64_pkg::RAD_W-1:0] edge_words[$];
    int failures;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero, tiny values around the first squares, the largest radicand,
    // the largest perfect square and the word just below it, alternating bit patterns
    edge_words = '{
      64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd8, 64'd9, 64'd15, 64'd16,
      64'd24, 64'd25,
      64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
      64'hFFFF_FFFE_0000_0001, 64'hFFFF_FFFE_0000_0000,
      64'hFFFF_FFFF_0000_0000,
      64'h4000_0000_0000_0000, 64'h8000_0000_0000_0000,
      64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
      64'h0000_0001_0000_0000, 64'h0000_0000_FFFF_FFFF,
      64'h0000_0000_0000_FFFF
    };
    foreach (edge_words[i]) send_word(edge_words[i]);

    repeat (RANDOM_WORDS) send_word(pick_radicand());
    in_valid <= 1'b0;

    // let every expected root come out, then give the pipe time to show
    // anything extra
    while (roots_in_flight != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    failures = mismatch_cnt + roots_in_flight;
    $display("%0d radicands sent (%0d edge, %0d random), %0d roots checked",
             words_sent, edge_words.size(), RANDOM_WORDS, roots_checked);
    $display("input held back for %0d cycles, long output hold-off %s",
             input_stall_cycles, hold_done ? "done" : "not reached");
    if (failures == 0) begin
      $display("tb_integer_square_root_64_top: PASS");
    end else begin
      $display("tb_integer_square_root_64_top: FAIL");
    end
    $finish;
  end

endmodule
